// ===== rtl/mdacrtc_pkg.sv =====
// Shared types and constants for the monochrome display adapter CRTC block.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package mdacrtc_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Port offsets above the index/data pairs.
    localparam logic [3:0] PORT_MODE   = 4'd8;
    localparam logic [3:0] PORT_STATUS = 4'd10;

    // CRTC register indexes.
    localparam int unsigned REG_HDISP     = 1;
    localparam int unsigned REG_VTOTAL    = 4;
    localparam int unsigned REG_VADJUST   = 5;
    localparam int unsigned REG_VDISP     = 6;
    localparam int unsigned REG_VSYNC     = 7;
    localparam int unsigned REG_INTERLACE = 8;
    localparam int unsigned REG_MAXSCAN   = 9;
    localparam int unsigned REG_CUR_START = 10;
    localparam int unsigned REG_CUR_END   = 11;
    localparam int unsigned REG_START_HI  = 12;
    localparam int unsigned REG_START_LO  = 13;
    localparam int unsigned REG_CUR_HI    = 14;
    localparam int unsigned REG_CUR_LO    = 15;
    localparam int unsigned NUM_REGS      = 32;

    localparam logic [7:0] CUR_FIX_START_OLD = 8'h06;
    localparam logic [7:0] CUR_FIX_END_OLD   = 8'h07;
    localparam logic [7:0] CUR_FIX_START_NEW = 8'h0b;
    localparam logic [7:0] CUR_FIX_END_NEW   = 8'h0c;

    // Interlace mode in the low bits of the interlace register, and the
    // cursor mode in bits 6:5 of cursor start that blanks the cursor.
    localparam logic [1:0] INTERLACE_MODE  = 2'b11;
    localparam logic [1:0] CUR_MODE_BLANK  = 2'b01;

    localparam logic [7:0] STATUS_ONES   = 8'hF0;
    localparam logic [7:0] UNMAPPED_READ = 8'hFF;
    localparam logic [4:0] VSYNC_LINES   = 5'd16;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] port_offset;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  status_bits;
        logic [13:0] row_address;
        logic [7:0]  character_count;
        logic        fetch_line;
        logic [4:0]  render_scanline;
        logic [13:0] cursor_address;
        logic        cursor_visible;
        logic        blink_active;
        logic        frame_sync;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/mda_crtc_timing_and_registers.sv =====
// Top level of the monochrome display adapter CRTC: port registers and half-line timing.
// Depends on mdacrtc_pkg for the item and result beat types and the register codes.
//
// Usage: every beat on the item channel is a port write, a port read or a
// half-line timing tick. Each item gives exactly one beat on the result channel.
// Both channels use valid and stall, and a beat moves when valid is high and
// stall is low. The result of an item appears in the cycle after the item is
// accepted. One item per cycle is sustained while the receiver does not stall,
// as set by the single result register: all state updates and the result are
// computed in the accept cycle. While the receiver stalls, the result register
// holds its beat. An item is still taken in a cycle where the held result is
// being taken. Otherwise item_stall is raised until the result register drains.
// Reset clears every CRTC register, the counters, the flags and the result valid.
// The block is ready for items as soon as reset is released.
`default_nettype none

module mda_crtc_timing_and_registers (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     item_valid,
    output logic                    item_stall,
    input  mdacrtc_pkg::item_t      item,
    output logic                    result_valid,
    input  wire                     result_stall,
    output mdacrtc_pkg::result_t    result
);
    import mdacrtc_pkg::*;

    logic [4:0]  index_reg,      index_next;
    logic [7:0]  crtc_regs_reg   [NUM_REGS];
    logic [7:0]  crtc_regs_next  [NUM_REGS];
    logic [7:0]  mode_reg,       mode_next;
    logic [7:0]  status_reg,     status_next;
    logic        phase_reg,      phase_next;
    logic [4:0]  scanline_reg,   scanline_next;
    logic [6:0]  row_count_reg,  row_count_next;
    logic [13:0] char_addr_reg,  char_addr_next;
    logic [13:0] row_start_reg,  row_start_next;
    logic [7:0]  adjust_reg,     adjust_next;
    logic        disp_en_reg,    disp_en_next;
    logic        cur_lines_reg,  cur_lines_next;
    logic        cur_blink_reg,  cur_blink_next;
    logic [4:0]  vsync_reg,      vsync_next;
    logic [4:0]  blink_reg,      blink_next;
    logic        result_valid_reg;
    result_t     result_reg,     result_next;

    logic accept;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A scanline matches a register value, or half of it in interlace mode.
    function automatic logic scan_match(input logic [4:0] scan, input logic [7:0] value,
                                        input logic interlace);
        logic [7:0] scan_ext;
        scan_ext = {3'd0, scan};
        return (scan_ext == value) || (interlace && scan_ext == {1'b0, value[7:1]});
    endfunction

    always_comb
    begin
        logic        interlace;
        logic [6:0]  prev_row;
        logic [7:0]  rd;
        logic [13:0] row_addr;
        logic        fetch;
        logic [4:0]  rscan;
        logic        fsync;

        index_next     = index_reg;
        crtc_regs_next = crtc_regs_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        phase_next     = phase_reg;
        scanline_next  = scanline_reg;
        row_count_next = row_count_reg;
        char_addr_next = char_addr_reg;
        row_start_next = row_start_reg;
        adjust_next    = adjust_reg;
        disp_en_next   = disp_en_reg;
        cur_lines_next = cur_lines_reg;
        cur_blink_next = cur_blink_reg;
        vsync_next     = vsync_reg;
        blink_next     = blink_reg;

        interlace = crtc_regs_reg[REG_INTERLACE][1:0] == INTERLACE_MODE;
        prev_row  = row_count_reg;
        rd        = UNMAPPED_READ;
        row_addr  = '0;
        fetch     = 1'b0;
        rscan     = '0;
        fsync     = 1'b0;

        if (accept)
        begin
            case (item.operation)
                OP_WRITE:
                begin
                    if (!item.port_offset[3])
                    begin
                        if (!item.port_offset[0])
                        begin
                            index_next = item.write_data[4:0];
                        end
                        else
                        begin
                            crtc_regs_next[index_reg] = item.write_data;
                            if (crtc_regs_next[REG_CUR_START] == CUR_FIX_START_OLD &&
                                crtc_regs_next[REG_CUR_END] == CUR_FIX_END_OLD)
                            begin
                                crtc_regs_next[REG_CUR_START] = CUR_FIX_START_NEW;
                                crtc_regs_next[REG_CUR_END]   = CUR_FIX_END_NEW;
                            end
                        end
                    end
                    else if (item.port_offset == PORT_MODE)
                    begin
                        mode_next = item.write_data;
                    end
                end
                OP_READ:
                begin
                    if (!item.port_offset[3])
                    begin
                        rd = item.port_offset[0] ? crtc_regs_reg[index_reg]
                                                 : {3'd0, index_reg};
                    end
                    else if (item.port_offset == PORT_STATUS)
                    begin
                        rd = status_reg | STATUS_ONES;
                    end
                end
                OP_TICK:
                begin
                    if (!phase_reg)
                    begin
                        // First half of the scanline: fetch the character line while display is enabled.
                        status_next[0] = 1'b1;
                        phase_next     = 1'b1;
                        rscan    = interlace ? {2'd0, scanline_reg[1:0], 1'b0} : scanline_reg;
                        row_addr = char_addr_reg;
                        if (disp_en_reg)
                        begin
                            fetch          = 1'b1;
                            char_addr_next = char_addr_reg + {6'd0, crtc_regs_reg[REG_HDISP]};
                        end
                        if ({1'b0, row_count_reg} == crtc_regs_reg[REG_VSYNC] &&
                            scanline_reg == 5'd0)
                        begin
                            status_next[3] = 1'b1;
                        end
                    end
                    else
                    begin
                        // Second half: step the line, row and frame counters.
                        if (disp_en_reg)
                        begin
                            status_next[0] = 1'b0;
                        end
                        phase_next = 1'b0;
                        if (vsync_reg != 5'd0)
                        begin
                            vsync_next = vsync_reg - 5'd1;
                            if (vsync_next == 5'd0)
                            begin
                                status_next[3] = 1'b0;
                            end
                        end
                        if (scan_match(scanline_reg,
                                       {3'd0, crtc_regs_reg[REG_CUR_END][4:0]}, interlace))
                        begin
                            cur_lines_next = 1'b0;
                        end

                        if (adjust_reg != 8'd0)
                        begin
                            scanline_next  = scanline_reg + 5'd1;
                            char_addr_next = row_start_reg;
                            adjust_next    = adjust_reg - 8'd1;
                            if (adjust_next == 8'd0)
                            begin
                                disp_en_next   = 1'b1;
                                row_start_next = {crtc_regs_reg[REG_START_HI][5:0],
                                                  crtc_regs_reg[REG_START_LO]};
                                char_addr_next = row_start_next;
                                scanline_next  = 5'd0;
                            end
                        end
                        else if (scan_match(scanline_reg, crtc_regs_reg[REG_MAXSCAN],
                                            interlace))
                        begin
                            row_start_next = char_addr_next;
                            scanline_next  = 5'd0;
                            row_count_next = row_count_reg + 7'd1;
                            if ({1'b0, row_count_next} == crtc_regs_reg[REG_VDISP])
                            begin
                                disp_en_next = 1'b0;
                            end
                            if ({1'b0, prev_row} == crtc_regs_reg[REG_VTOTAL])
                            begin
                                row_count_next = 7'd0;
                                adjust_next    = crtc_regs_reg[REG_VADJUST];
                                if (adjust_next == 8'd0)
                                begin
                                    disp_en_next   = 1'b1;
                                    row_start_next = {crtc_regs_reg[REG_START_HI][5:0],
                                                      crtc_regs_reg[REG_START_LO]};
                                    char_addr_next = row_start_next;
                                end
                                // Cursor start bits 6:5 equal to 01 blank the cursor.
                                if (crtc_regs_reg[REG_CUR_START][6:5] == CUR_MODE_BLANK)
                                begin
                                    cur_blink_next = 1'b0;
                                end
                                else
                                begin
                                    cur_blink_next = blink_reg[4];
                                end
                            end
                            if ({1'b0, row_count_next} == crtc_regs_reg[REG_VSYNC])
                            begin
                                disp_en_next = 1'b0;
                                vsync_next   = VSYNC_LINES;
                                blink_next   = blink_reg + 5'd1;
                                fsync        = 1'b1;
                            end
                        end
                        else
                        begin
                            scanline_next  = scanline_reg + 5'd1;
                            char_addr_next = row_start_reg;
                        end

                        if (scan_match(scanline_next,
                                       {3'd0, crtc_regs_reg[REG_CUR_START][4:0]}, interlace))
                        begin
                            cur_lines_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        result_next.read_data       = rd;
        result_next.status_bits     = status_next | STATUS_ONES;
        result_next.row_address     = row_addr;
        result_next.character_count = crtc_regs_next[REG_HDISP];
        result_next.fetch_line      = fetch;
        result_next.render_scanline = rscan;
        result_next.cursor_address  = {crtc_regs_next[REG_CUR_HI][5:0],
                                       crtc_regs_next[REG_CUR_LO]};
        result_next.cursor_visible  = cur_lines_next & cur_blink_next;
        result_next.blink_active    = mode_next[5] & blink_next[4];
        result_next.frame_sync      = fsync;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                crtc_regs_reg[i] <= '0;
            end
            mode_reg      <= '0;
            status_reg    <= '0;
            phase_reg     <= 1'b0;
            scanline_reg  <= '0;
            row_count_reg <= '0;
            char_addr_reg <= '0;
            row_start_reg <= '0;
            adjust_reg    <= '0;
            disp_en_reg   <= 1'b0;
            cur_lines_reg <= 1'b0;
            cur_blink_reg <= 1'b0;
            vsync_reg     <= '0;
            blink_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg     <= index_next;
            crtc_regs_reg <= crtc_regs_next;
            mode_reg      <= mode_next;
            status_reg    <= status_next;
            phase_reg     <= phase_next;
            scanline_reg  <= scanline_next;
            row_count_reg <= row_count_next;
            char_addr_reg <= char_addr_next;
            row_start_reg <= row_start_next;
            adjust_reg    <= adjust_next;
            disp_en_reg   <= disp_en_next;
            cur_lines_reg <= cur_lines_next;
            cur_blink_reg <= cur_blink_next;
            vsync_reg     <= vsync_next;
            blink_reg     <= blink_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mdacrtc_checker.sv =====
// Port-level checker for the MDA CRTC top level, and the bind that attaches it.
// Depends on mdacrtc_pkg for the beat types.
`default_nettype none

module mdacrtc_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  item_valid,
    input wire                  item_stall,
    input wire                  result_valid,
    input wire                  result_stall,
    input mdacrtc_pkg::result_t result
);
    import mdacrtc_pkg::*;

    // The item side only waits on a full, stalled result register.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item_stall raised with no result beat pending");

    // Every accepted item gives a result beat in the next cycle.
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> result_valid)
        else $error("accepted item produced no result beat");

    a_status_ones: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status_bits[7:4] == STATUS_ONES[7:4]))
        else $error("status upper nibble not all ones");

    // Only ticks fetch lines, and ticks never return read data.
    a_fetch_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.fetch_line) |->
            (result.read_data == UNMAPPED_READ && !result.frame_sync))
        else $error("fetch beat carries read data or frame sync");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result beat changed");

endmodule

bind mda_crtc_timing_and_registers mdacrtc_checker u_mdacrtc_checker (.*);

`default_nettype wire
